/* rtl/tpff_pkg.sv */
package tpff_pkg;

   // Frame positions at or beyond this limit are not captured
   localparam int unsigned MAX_FRAME = 65536;

   // Register reset values
   localparam logic [15:0] PORT_ONE_RST  = 16'd80;
   localparam logic [15:0] PORT_TWO_RST  = 16'd443;
   localparam logic [15:0] ETHERTYPE_RST = 16'h0800;
   localparam logic [7:0]  PROTOCOL_RST  = 8'd6;

   // Register indexes
   typedef logic [7:0] csr_idx_type;
   localparam csr_idx_type CSR_PORT_ONE        = 8'd0;
   localparam csr_idx_type CSR_PORT_TWO        = 8'd1;
   localparam csr_idx_type CSR_ETHERTYPE_MATCH = 8'd2;
   localparam csr_idx_type CSR_PROTOCOL_MATCH  = 8'd3;

   // Fixed byte positions in the frame
   localparam logic [15:0] POS_ETYPE_HI = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO = 16'd13;
   localparam logic [15:0] POS_IHL      = 16'd14;
   localparam logic [15:0] POS_TTL      = 16'd22;
   localparam logic [15:0] POS_PROTO    = 16'd23;
   localparam logic [15:0] POS_SRC_IP   = 16'd26;
   localparam logic [15:0] POS_SRC_END  = 16'd29;
   localparam logic [15:0] POS_DST_IP   = 16'd30;
   localparam logic [15:0] POS_DST_END  = 16'd33;
   localparam logic [15:0] CNT_MAX      = 16'hFFFF;

   // Header lengths
   localparam logic [7:0] ETH_HDR_LEN = 8'd14;
   localparam logic [7:0] TCP_MIN_LEN = 8'd20;
   localparam logic [7:0] IP_END_LEN  = 8'd34;

   // Offsets inside the TCP header
   localparam logic [4:0] TCP_SPORT_END = 5'd1;
   localparam logic [4:0] TCP_DPORT_END = 5'd3;
   localparam logic [4:0] TCP_SEQ_END   = 5'd7;
   localparam logic [4:0] TCP_ACK_END   = 5'd11;
   localparam logic [4:0] TCP_DOFF      = 5'd12;
   localparam logic [4:0] TCP_FLAGS     = 5'd13;
   localparam logic [4:0] TCP_WIN_END   = 5'd15;
   localparam logic [4:0] TCP_LAST      = 5'd19;

   typedef enum logic [2:0] {
      ST_ACCEPT    = 3'd0,
      ST_SHORT_ETH = 3'd1,
      ST_NOT_IPV4  = 3'd2,
      ST_SHORT_IP  = 3'd3,
      ST_NOT_TCP   = 3'd4,
      ST_SHORT_TCP = 3'd5,
      ST_PORT_MISS = 3'd6
   } status_type;

   typedef struct packed {
      logic [15:0] port_one;
      logic [15:0] port_two;
      logic [15:0] ethertype_match;
      logic [7:0]  protocol_match;
   } cfg_type;

   // Handshake control from the input stage
   typedef struct packed {
      logic advance;
      logic last;
   } beat_ctl_type;

   // Per-frame capture state
   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] ethertype;
      logic [3:0]  ip_words;
      logic [7:0]  protocol;
      logic [7:0]  ttl;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [7:0]  flags;
      logic [15:0] window;
      logic [3:0]  tcp_words;
   } hdr_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [7:0]  ttl;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [31:0] sequence_number;
      logic [31:0] ack_number;
      logic [7:0]  tcp_flags;
      logic [15:0] window_size;
      logic [15:0] payload_length;
      logic [15:0] frame_length;
   } result_type;

endpackage

/* rtl/tpff_if.sv */
// Frame byte channel
interface tpff_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// Per-frame result channel
interface tpff_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [7:0]  ttl;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [31:0] sequence_number;
   logic [31:0] ack_number;
   logic [7:0]  tcp_flags;
   logic [15:0] window_size;
   logic [15:0] payload_length;
   logic [15:0] frame_length;

   modport source (output valid, output status, output src_ip, output dst_ip, output ttl,
                   output source_port, output dest_port, output sequence_number,
                   output ack_number, output tcp_flags, output window_size,
                   output payload_length, output frame_length, input ready);
   modport sink   (input valid, input status, input src_ip, input dst_ip, input ttl,
                   input source_port, input dest_port, input sequence_number,
                   input ack_number, input tcp_flags, input window_size,
                   input payload_length, input frame_length, output ready);
endinterface

// Register write channel
interface tpff_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/tpff_capture.sv */
module tpff_capture (
   input  logic                  clock,
   input  logic                  reset,
   input  tpff_pkg::beat_ctl_type ctl,
   input  logic [7:0]            frame_byte,
   output tpff_pkg::hdr_type     hdr_next
);

   tpff_pkg::hdr_type hdr_ff;
   tpff_pkg::hdr_type hdr_in;
   logic [15:0]       pos;
   logic              capture_en;
   logic [6:0]        tcp_start;
   logic [15:0]       tcp_off;
   logic              in_tcp;
   logic [4:0]        off;

   assign pos        = hdr_ff.byte_count;
   assign capture_en = {1'b0, pos} < 17'(tpff_pkg::MAX_FRAME);

   // Capture by byte position; the IHL of byte 14 already places the TCP header
   always_comb begin
      hdr_in = hdr_ff;
      if (capture_en) begin
         if (pos == tpff_pkg::POS_ETYPE_HI || pos == tpff_pkg::POS_ETYPE_LO)
            hdr_in.ethertype = {hdr_ff.ethertype[7:0], frame_byte};
         if (pos == tpff_pkg::POS_IHL)
            hdr_in.ip_words = frame_byte[3:0];
         if (pos == tpff_pkg::POS_TTL)
            hdr_in.ttl = frame_byte;
         if (pos == tpff_pkg::POS_PROTO)
            hdr_in.protocol = frame_byte;
         if (pos >= tpff_pkg::POS_SRC_IP && pos <= tpff_pkg::POS_SRC_END)
            hdr_in.src_addr = {hdr_ff.src_addr[23:0], frame_byte};
         if (pos >= tpff_pkg::POS_DST_IP && pos <= tpff_pkg::POS_DST_END)
            hdr_in.dst_addr = {hdr_ff.dst_addr[23:0], frame_byte};
      end
      tcp_start = 7'(tpff_pkg::ETH_HDR_LEN) + {1'b0, hdr_in.ip_words, 2'b00};
      tcp_off   = pos - {9'd0, tcp_start};
      in_tcp    = capture_en && (pos >= {9'd0, tcp_start}) &&
                  (tcp_off <= {11'd0, tpff_pkg::TCP_LAST});
      off       = tcp_off[4:0];
      if (in_tcp) begin
         if (off <= tpff_pkg::TCP_SPORT_END)
            hdr_in.source_port = {hdr_ff.source_port[7:0], frame_byte};
         else if (off <= tpff_pkg::TCP_DPORT_END)
            hdr_in.dest_port = {hdr_ff.dest_port[7:0], frame_byte};
         else if (off <= tpff_pkg::TCP_SEQ_END)
            hdr_in.seq = {hdr_ff.seq[23:0], frame_byte};
         else if (off <= tpff_pkg::TCP_ACK_END)
            hdr_in.ack = {hdr_ff.ack[23:0], frame_byte};
         else if (off == tpff_pkg::TCP_DOFF)
            hdr_in.tcp_words = frame_byte[7:4];
         else if (off == tpff_pkg::TCP_FLAGS)
            hdr_in.flags = frame_byte;
         else if (off <= tpff_pkg::TCP_WIN_END)
            hdr_in.window = {hdr_ff.window[7:0], frame_byte};
      end
      // saturating byte counter
      if (pos != tpff_pkg::CNT_MAX)
         hdr_in.byte_count = pos + 16'd1;
   end

   assign hdr_next = hdr_in;

   // State clears after the last beat of a frame
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
      end else if (ctl.advance) begin
         hdr_ff <= ctl.last ? '0 : hdr_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && ctl.last |=> hdr_ff.byte_count == 16'd0)
      else $error("capture state not cleared after frame end");

   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && !ctl.last && hdr_ff.byte_count != tpff_pkg::CNT_MAX
      |=> hdr_ff.byte_count == $past(hdr_ff.byte_count) + 16'd1)
      else $error("byte count did not advance");

endmodule

/* rtl/tpff_classify.sv */
module tpff_classify (
   input  logic                   clock,
   input  logic                   reset,
   input  tpff_pkg::beat_ctl_type ctl,
   input  tpff_pkg::cfg_type      cfg,
   input  tpff_pkg::hdr_type      hdr_next,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output tpff_pkg::result_type   result,
   output logic                   slot_free
);

   logic                 rsp_valid_ff;
   tpff_pkg::result_type result_ff;
   tpff_pkg::result_type result_in;
   logic [16:0]          len_full;
   logic [15:0]          len;
   logic [7:0]           ip_hdr_len;
   logic [7:0]           tcp_end;
   logic [7:0]           all_len;
   logic                 src_ok;
   logic                 dst_ok;
   logic                 load;

   // Frame length limited to the capture window
   assign len_full = ({1'b0, hdr_next.byte_count} < 17'(tpff_pkg::MAX_FRAME)) ?
                     {1'b0, hdr_next.byte_count} : 17'(tpff_pkg::MAX_FRAME);
   assign len      = len_full[15:0];

   assign ip_hdr_len = tpff_pkg::ETH_HDR_LEN + {2'b00, hdr_next.ip_words, 2'b00};
   assign tcp_end    = ip_hdr_len + tpff_pkg::TCP_MIN_LEN;
   assign all_len    = ip_hdr_len + {2'b00, hdr_next.tcp_words, 2'b00};

   assign src_ok = hdr_next.source_port == cfg.port_one ||
                   hdr_next.source_port == cfg.port_two;
   assign dst_ok = hdr_next.dest_port == cfg.port_one ||
                   hdr_next.dest_port == cfg.port_two;

   // Checks in priority order, fields only for an accepted frame
   always_comb begin
      result_in              = '0;
      result_in.frame_length = len;
      if (len < {8'd0, tpff_pkg::ETH_HDR_LEN})
         result_in.status = tpff_pkg::ST_SHORT_ETH;
      else if (hdr_next.ethertype != cfg.ethertype_match)
         result_in.status = tpff_pkg::ST_NOT_IPV4;
      else if (len < {8'd0, tpff_pkg::IP_END_LEN})
         result_in.status = tpff_pkg::ST_SHORT_IP;
      else if (hdr_next.protocol != cfg.protocol_match)
         result_in.status = tpff_pkg::ST_NOT_TCP;
      else if (len < {8'd0, tcp_end})
         result_in.status = tpff_pkg::ST_SHORT_TCP;
      else if (!src_ok && !dst_ok)
         result_in.status = tpff_pkg::ST_PORT_MISS;
      else
         result_in.status = tpff_pkg::ST_ACCEPT;

      if (result_in.status == tpff_pkg::ST_ACCEPT) begin
         result_in.src_ip          = hdr_next.src_addr;
         result_in.dst_ip          = hdr_next.dst_addr;
         result_in.ttl             = hdr_next.ttl;
         result_in.source_port     = hdr_next.source_port;
         result_in.dest_port       = hdr_next.dest_port;
         result_in.sequence_number = hdr_next.seq;
         result_in.ack_number      = hdr_next.ack;
         result_in.tcp_flags       = hdr_next.flags;
         result_in.window_size     = hdr_next.window;
         result_in.payload_length  = (len > {8'd0, all_len}) ?
                                     len - {8'd0, all_len} : 16'd0;
      end
   end

   assign load      = ctl.advance && ctl.last;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free)
      else $error("result loaded over an untaken result");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status != tpff_pkg::ST_ACCEPT
      |-> result_ff.src_ip == 32'd0 && result_ff.payload_length == 16'd0)
      else $error("rejected frame carries header fields");

endmodule

/* rtl/tcp_port_frame_filter_top.sv */
// TCP port frame filter.
// req carries one frame byte per beat with last_byte on the final byte.
// Each frame yields exactly one beat on rsp: a status (checked in order:
// short Ethernet, EtherType, short IP, protocol, short TCP, port match)
// plus the captured IPv4/TCP header fields, payload length and frame length.
// csr writes port_one (0), port_two (1), ethertype_match (2) and
// protocol_match (3); other indexes are ignored. Write it only while idle.
// Throughput: one byte per cycle, sustained, as long as rsp drains.
// The result passes from the input register through the capture/classify logic
// into the result register once a free result slot lets the last byte advance.
// Reset loads the register defaults (80, 443, 0x0800, 6), clears the capture
// state and drops any pending result.
// When rsp stalls, the result is held; the byte stream keeps flowing until
// the next last byte reaches the input register, which then waits for the
// result slot, and req.ready stays low until rsp takes the held result.
module tcp_port_frame_filter_top (
   input logic        clock,
   input logic        reset,
   tpff_req_if.sink   req,
   tpff_rsp_if.source rsp,
   tpff_csr_if.sink   csr
);

   tpff_pkg::cfg_type      cfg_ff;
   logic                   s1_valid_ff;
   logic [7:0]             s1_byte_ff;
   logic                   s1_last_ff;
   logic                   advance;
   logic                   slot_free;
   logic                   rsp_valid;
   tpff_pkg::beat_ctl_type ctl;
   tpff_pkg::hdr_type      hdr_next;
   tpff_pkg::result_type   result;

   // Register file
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_one        <= tpff_pkg::PORT_ONE_RST;
         cfg_ff.port_two        <= tpff_pkg::PORT_TWO_RST;
         cfg_ff.ethertype_match <= tpff_pkg::ETHERTYPE_RST;
         cfg_ff.protocol_match  <= tpff_pkg::PROTOCOL_RST;
      end else if (csr.valid) begin
         unique case (csr.index)
            tpff_pkg::CSR_PORT_ONE:        cfg_ff.port_one        <= csr.data;
            tpff_pkg::CSR_PORT_TWO:        cfg_ff.port_two        <= csr.data;
            tpff_pkg::CSR_ETHERTYPE_MATCH: cfg_ff.ethertype_match <= csr.data;
            tpff_pkg::CSR_PROTOCOL_MATCH:  cfg_ff.protocol_match  <= csr.data[7:0];
            default: ;
         endcase
      end
   end

   // Input register; a last byte waits for a free result slot
   assign advance   = s1_valid_ff && (!s1_last_ff || slot_free);
   assign req.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_byte_ff <= req.frame_byte;
         s1_last_ff <= req.last_byte;
      end
   end

   assign ctl.advance = advance;
   assign ctl.last    = s1_last_ff;

   tpff_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .frame_byte (s1_byte_ff),
      .hdr_next   (hdr_next)
   );

   tpff_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cfg       (cfg_ff),
      .hdr_next  (hdr_next),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp_valid),
      .result    (result),
      .slot_free (slot_free)
   );

   // Result beat
   assign rsp.valid           = rsp_valid;
   assign rsp.status          = result.status;
   assign rsp.src_ip          = result.src_ip;
   assign rsp.dst_ip          = result.dst_ip;
   assign rsp.ttl             = result.ttl;
   assign rsp.source_port     = result.source_port;
   assign rsp.dest_port       = result.dest_port;
   assign rsp.sequence_number = result.sequence_number;
   assign rsp.ack_number      = result.ack_number;
   assign rsp.tcp_flags       = result.tcp_flags;
   assign rsp.window_size     = result.window_size;
   assign rsp.payload_length  = result.payload_length;
   assign rsp.frame_length    = result.frame_length;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> rsp_valid)
      else $error("frame end produced no result");

   a_last_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && !slot_free |=> s1_valid_ff && s1_last_ff)
      else $error("stalled last byte lost");

endmodule

/* verif/tb_tcp_port_frame_filter_top.sv */
module tb_tcp_port_frame_filter_top;

   // Register indexes outside the decoded range, written to prove they are ignored
   localparam tpff_pkg::csr_idx_type CSR_UNUSED_LOW = 8'd4;
   localparam tpff_pkg::csr_idx_type CSR_UNUSED_TOP = 8'hFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpff_req_if req_if ();
   tpff_rsp_if rsp_if ();
   tpff_csr_if csr_if ();

   tcp_port_frame_filter_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor copy of the filter registers and the per-frame capture state
   tpff_pkg::cfg_type     filter_cfg;
   tpff_pkg::hdr_type     parse_state;
   tpff_pkg::result_type  pending_verdicts[$];
   logic [7:0]            frame_buf[$];

   int  fault_count = 0;
   int  bytes_sent  = 0;
   int  frames_sent = 0;
   int  rsp_stall   = 0;
   bit  steady_flow = 1'b0;

   initial begin
      #2000000;
      $display("tb_tcp_port_frame_filter_top: done, errors");
      $finish;
   end

   function automatic bit port_hit(logic [15:0] port);
      return port == filter_cfg.port_one || port == filter_cfg.port_two;
   endfunction

   // Capture one accepted byte; on the last byte, queue the frame verdict
   function automatic void track_frame_byte(logic [7:0] b, logic last);
      logic [15:0] pos;
      int unsigned tcp_start, off, frame_len, hdr_end, hdr_all;
      tpff_pkg::result_type verdict;
      pos = parse_state.byte_count;
      // every position below the counter limit lies under MAX_FRAME
      if (pos < tpff_pkg::MAX_FRAME) begin
         if (pos == tpff_pkg::POS_ETYPE_HI || pos == tpff_pkg::POS_ETYPE_LO)
            parse_state.ethertype = {parse_state.ethertype[7:0], b};
         if (pos == tpff_pkg::POS_IHL) parse_state.ip_words = b[3:0];
         if (pos == tpff_pkg::POS_TTL) parse_state.ttl = b;
         if (pos == tpff_pkg::POS_PROTO) parse_state.protocol = b;
         if (pos >= tpff_pkg::POS_SRC_IP && pos <= tpff_pkg::POS_SRC_END)
            parse_state.src_addr = {parse_state.src_addr[23:0], b};
         if (pos >= tpff_pkg::POS_DST_IP && pos <= tpff_pkg::POS_DST_END)
            parse_state.dst_addr = {parse_state.dst_addr[23:0], b};
         // TCP window moves with the IHL, which may already come from this byte
         tcp_start = tpff_pkg::ETH_HDR_LEN + parse_state.ip_words * 4;
         if (pos >= tpff_pkg::POS_IHL && pos >= tcp_start &&
             pos <= tcp_start + tpff_pkg::TCP_LAST) begin
            off = pos - tcp_start;
            if (off <= tpff_pkg::TCP_SPORT_END)
               parse_state.source_port = {parse_state.source_port[7:0], b};
            else if (off <= tpff_pkg::TCP_DPORT_END)
               parse_state.dest_port = {parse_state.dest_port[7:0], b};
            else if (off <= tpff_pkg::TCP_SEQ_END)
               parse_state.seq = {parse_state.seq[23:0], b};
            else if (off <= tpff_pkg::TCP_ACK_END)
               parse_state.ack = {parse_state.ack[23:0], b};
            else if (off == tpff_pkg::TCP_DOFF)
               parse_state.tcp_words = b[7:4];
            else if (off == tpff_pkg::TCP_FLAGS)
               parse_state.flags = b;
            else if (off <= tpff_pkg::TCP_WIN_END)
               parse_state.window = {parse_state.window[7:0], b};
         end
      end
      if (parse_state.byte_count != tpff_pkg::CNT_MAX) parse_state.byte_count++;
      if (!last) return;

      frame_len = (parse_state.byte_count < tpff_pkg::MAX_FRAME) ?
                  parse_state.byte_count : tpff_pkg::MAX_FRAME;
      hdr_end   = tpff_pkg::ETH_HDR_LEN + parse_state.ip_words * 4;
      verdict   = '0;
      if (frame_len < tpff_pkg::ETH_HDR_LEN)
         verdict.status = tpff_pkg::ST_SHORT_ETH;
      else if (parse_state.ethertype != filter_cfg.ethertype_match)
         verdict.status = tpff_pkg::ST_NOT_IPV4;
      else if (frame_len < tpff_pkg::IP_END_LEN)
         verdict.status = tpff_pkg::ST_SHORT_IP;
      else if (parse_state.protocol != filter_cfg.protocol_match)
         verdict.status = tpff_pkg::ST_NOT_TCP;
      else if (frame_len < hdr_end + tpff_pkg::TCP_MIN_LEN)
         verdict.status = tpff_pkg::ST_SHORT_TCP;
      else if (!port_hit(parse_state.source_port) && !port_hit(parse_state.dest_port))
         verdict.status = tpff_pkg::ST_PORT_MISS;
      else
         verdict.status = tpff_pkg::ST_ACCEPT;
      verdict.frame_length = frame_len[15:0];
      // rejected frames report only status and length
      if (verdict.status == tpff_pkg::ST_ACCEPT) begin
         hdr_all = hdr_end + parse_state.tcp_words * 4;
         verdict.src_ip          = parse_state.src_addr;
         verdict.dst_ip          = parse_state.dst_addr;
         verdict.ttl             = parse_state.ttl;
         verdict.source_port     = parse_state.source_port;
         verdict.dest_port       = parse_state.dest_port;
         verdict.sequence_number = parse_state.seq;
         verdict.ack_number      = parse_state.ack;
         verdict.tcp_flags       = parse_state.flags;
         verdict.window_size     = parse_state.window;
         verdict.payload_length  = (frame_len > hdr_all) ? 16'(frame_len - hdr_all) : 16'd0;
      end
      pending_verdicts.push_back(verdict);
      parse_state = '0;
   endfunction

   function automatic logic [31:0] field_of(tpff_pkg::result_type r, int k);
      case (k)
         0:  return 32'(r.status);
         1:  return r.src_ip;
         2:  return r.dst_ip;
         3:  return 32'(r.ttl);
         4:  return 32'(r.source_port);
         5:  return 32'(r.dest_port);
         6:  return r.sequence_number;
         7:  return r.ack_number;
         8:  return 32'(r.tcp_flags);
         9:  return 32'(r.window_size);
         10: return 32'(r.payload_length);
         default: return 32'(r.frame_length);
      endcase
   endfunction

   function automatic string field_name(int k);
      case (k)
         0:  return "status";
         1:  return "src_ip";
         2:  return "dst_ip";
         3:  return "ttl";
         4:  return "source_port";
         5:  return "dest_port";
         6:  return "sequence_number";
         7:  return "ack_number";
         8:  return "tcp_flags";
         9:  return "window_size";
         10: return "payload_length";
         default: return "frame_length";
      endcase
   endfunction

   // Result side: compare each beat against the oldest verdict, random stalls on ready
   always @(posedge clock) begin : rsp_side
      tpff_pkg::result_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.status          = tpff_pkg::status_type'(rsp_if.status);
            got.src_ip          = rsp_if.src_ip;
            got.dst_ip          = rsp_if.dst_ip;
            got.ttl             = rsp_if.ttl;
            got.source_port     = rsp_if.source_port;
            got.dest_port       = rsp_if.dest_port;
            got.sequence_number = rsp_if.sequence_number;
            got.ack_number      = rsp_if.ack_number;
            got.tcp_flags       = rsp_if.tcp_flags;
            got.window_size     = rsp_if.window_size;
            got.payload_length  = rsp_if.payload_length;
            got.frame_length    = rsp_if.frame_length;
            if (pending_verdicts.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected result beat: status %0d frame_length %0d",
                           rsp_if.status, rsp_if.frame_length);
            end else begin
               want = pending_verdicts.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= 10)
                     for (int k = 0; k < 12; k++)
                        if (field_of(got, k) !== field_of(want, k))
                           $display("mismatch %s: expected %0h, actual %0h",
                                    field_name(k), field_of(want, k), field_of(got, k));
               end
            end
            rsp_stall = steady_flow ? 0 : $urandom_range(0, 9);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_if.ready <= (rsp_stall == 0);
      end
   end

   // Send one byte after a random gap; valid stays high for back-to-back beats
   task automatic push_frame_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.frame_byte <= b;
      req_if.last_byte  <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      track_frame_byte(b, last);
      bytes_sent++;
   endtask

   function automatic void put_bytes(int unsigned pos, int n, logic [31:0] val);
      for (int i = 0; i < n; i++)
         if (pos + i < frame_buf.size())
            frame_buf[pos + i] = 8'(val >> (8 * (n - 1 - i)));
   endfunction

   // Random frame body with the given header fields laid over it
   function automatic void compose_frame(logic [15:0] etype, logic [3:0] ihl, logic [7:0] proto,
                                         logic [15:0] sport, logic [15:0] dport,
                                         logic [3:0] doff, int unsigned total);
      int unsigned tcp_start;
      logic [7:0]  rb;
      logic [3:0]  nib;
      frame_buf.delete();
      repeat (total) begin
         rb = 8'($urandom_range(0, 255));
         frame_buf.push_back(rb);
      end
      tcp_start = 14 + ihl * 4;
      put_bytes(tcp_start, 2, 32'(sport));
      put_bytes(tcp_start + 2, 2, 32'(dport));
      nib = 4'($urandom_range(0, 15));
      put_bytes(tcp_start + 12, 1, 32'({doff, nib}));
      // IP fields last, so an overlapping TCP header cannot disturb the IHL
      put_bytes(12, 2, 32'(etype));
      nib = 4'($urandom_range(0, 15));
      put_bytes(14, 1, 32'({nib, ihl}));
      put_bytes(23, 1, 32'(proto));
   endfunction

   task automatic ship_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         push_frame_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   // Hold the sender until every verdict has come back and the block is idle
   task automatic settle_block();
      int spin;
      req_if.valid <= 1'b0;
      @(posedge clock);
      spin = 0;
      while (pending_verdicts.size() != 0 && spin < 5000) begin
         @(posedge clock);
         spin++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_beat(input tpff_pkg::csr_idx_type idx, input logic [15:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         tpff_pkg::CSR_PORT_ONE:        filter_cfg.port_one = val;
         tpff_pkg::CSR_PORT_TWO:        filter_cfg.port_two = val;
         tpff_pkg::CSR_ETHERTYPE_MATCH: filter_cfg.ethertype_match = val;
         tpff_pkg::CSR_PROTOCOL_MATCH:  filter_cfg.protocol_match = val[7:0];
         default: ;
      endcase
   endtask

   // Write all four registers back to back, optionally followed by undecoded indexes
   task automatic program_filter(input logic [15:0] p1, input logic [15:0] p2,
                                 input logic [15:0] et, input logic [7:0] pr,
                                 input bit poke_unused);
      csr_beat(tpff_pkg::CSR_PORT_ONE, p1);
      csr_beat(tpff_pkg::CSR_PORT_TWO, p2);
      csr_beat(tpff_pkg::CSR_ETHERTYPE_MATCH, et);
      csr_beat(tpff_pkg::CSR_PROTOCOL_MATCH, {8'd0, pr});
      if (poke_unused) begin
         csr_beat(CSR_UNUSED_LOW, 16'($urandom_range(0, 65535)));
         csr_beat(CSR_UNUSED_TOP, 16'($urandom_range(0, 65535)));
      end
      csr_if.valid <= 1'b0;
   endtask

   // Accepted frames under reset defaults: port hits, options, IHL and offset extremes
   task automatic test_header_fields();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd1234, 16'd80, 4'd5, 54);
      ship_frame();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd443, 16'd999, 4'd8, 86);
      ship_frame();
      compose_frame(16'h0800, 4'd15, 8'd6, 16'd80, 16'd443, 4'd5, 120);
      ship_frame();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd80, 16'd7, 4'd0, 70);
      ship_frame();
      // data offset past the frame end: payload clamps to zero
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd7, 16'd443, 4'd15, 60);
      ship_frame();
   endtask

   // Frames for every rejection status, including the length boundaries
   task automatic test_rejections();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd80, 16'd80, 4'd5, 1);
      ship_frame();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd80, 16'd80, 4'd5, 13);
      ship_frame();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd80, 16'd80, 4'd5, 14);
      ship_frame();
      compose_frame(16'h86DD, 4'd5, 8'd6, 16'd80, 16'd80, 4'd5, 60);
      ship_frame();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd80, 16'd80, 4'd5, 33);
      ship_frame();
      compose_frame(16'h0800, 4'd5, 8'd17, 16'd80, 16'd80, 4'd5, 60);
      ship_frame();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd80, 16'd80, 4'd5, 53);
      ship_frame();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd1, 16'd2, 4'd5, 60);
      ship_frame();
   endtask

   // IHL below five: TCP header overlaps the IP header
   task automatic test_short_ihl();
      compose_frame(16'h0800, 4'd0, 8'd6, 16'd80, 16'd80, 4'd5, 40);
      ship_frame();
      compose_frame(16'h0800, 4'd2, 8'd6, 16'd80, 16'd443, 4'd5, 50);
      ship_frame();
      compose_frame(16'h0800, 4'd4, 8'd6, 16'd443, 16'd80, 4'd5, 54);
      ship_frame();
   endtask

   task automatic test_register_extremes();
      settle_block();
      program_filter(16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
      compose_frame(16'hFFFF, 4'd5, 8'hFF, 16'h0000, 16'd9, 4'd5, 60);
      ship_frame();
      compose_frame(16'hFFFF, 4'd5, 8'hFF, 16'd9, 16'hFFFF, 4'd5, 60);
      ship_frame();
      compose_frame(16'h0800, 4'd5, 8'd6, 16'd80, 16'd443, 4'd5, 60);
      ship_frame();
      settle_block();
      program_filter(16'hFFFF, 16'h0000, 16'h0000, 8'h00, 1'b1);
      compose_frame(16'h0000, 4'd5, 8'h00, 16'hFFFF, 16'd1, 4'd5, 60);
      ship_frame();
      compose_frame(16'h0000, 4'd5, 8'h00, 16'd1, 16'h0000, 4'd5, 60);
      ship_frame();
      compose_frame(16'h0000, 4'd5, 8'h00, 16'd1, 16'd2, 4'd5, 60);
      ship_frame();
   endtask

   // Mostly well-formed frames against the current registers, some broken, some noise
   task automatic random_frame();
      int unsigned kind, tcp_start, total;
      logic [3:0]  ihl, doff;
      logic [15:0] etype, sport, dport;
      logic [7:0]  proto;
      kind = $urandom_range(0, 99);
      ihl  = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 4) != 0) ihl = 4'd5;
      doff = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 2) != 0) doff = 4'd5;
      etype = filter_cfg.ethertype_match;
      proto = filter_cfg.protocol_match;
      sport = 16'($urandom_range(0, 65535));
      dport = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
         0: sport = filter_cfg.port_one;
         1: dport = filter_cfg.port_two;
         2: begin
            sport = filter_cfg.port_two;
            dport = filter_cfg.port_one;
         end
         default: ;
      endcase
      tcp_start = 14 + ihl * 4;
      total = tcp_start + ((doff > 5) ? doff * 4 : 20) + $urandom_range(0, 24);
      if (total < 34) total = 34 + $urandom_range(0, 8);
      if (kind >= 70 && kind < 88) begin
         case ($urandom_range(0, 2))
            0: etype = etype ^ (16'd1 << $urandom_range(0, 15));
            1: proto = proto ^ (8'd1 << $urandom_range(0, 7));
            default: total = $urandom_range(1, total - 1);
         endcase
      end else if (kind >= 88) begin
         etype = 16'($urandom_range(0, 65535));
         proto = 8'($urandom_range(0, 255));
         total = $urandom_range(1, 40);
      end
      compose_frame(etype, ihl, proto, sport, dport, doff, total);
      ship_frame();
   endtask

   // Random traffic tops the run up to about 1950 bytes
   task automatic test_random_traffic();
      int phase;
      int start_frames;
      logic [15:0] p1, p2, et;
      logic [7:0]  pr;
      phase = 0;
      start_frames = frames_sent;
      while (bytes_sent < 1950 || frames_sent - start_frames < 12) begin
         // new register setting every four frames, one setting without idling
         if ((frames_sent - start_frames) % 4 == 0) begin
            settle_block();
            p1 = 16'($urandom_range(0, 65535));
            p2 = ($urandom_range(0, 3) == 0) ? p1 : 16'($urandom_range(0, 65535));
            et = ($urandom_range(0, 1) == 0) ? 16'h0800 : 16'($urandom_range(0, 65535));
            pr = 8'($urandom_range(0, 255));
            program_filter(p1, p2, et, pr, phase == 1);
            steady_flow = (phase == 2);
            phase++;
         end
         random_frame();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      req_if.valid      <= 1'b0;
      req_if.frame_byte <= 8'd0;
      req_if.last_byte  <= 1'b0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= tpff_pkg::CSR_PORT_ONE;
      csr_if.data       <= 16'd0;
      filter_cfg.port_one        = tpff_pkg::PORT_ONE_RST;
      filter_cfg.port_two        = tpff_pkg::PORT_TWO_RST;
      filter_cfg.ethertype_match = tpff_pkg::ETHERTYPE_RST;
      filter_cfg.protocol_match  = tpff_pkg::PROTOCOL_RST;
      parse_state = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_header_fields();
      test_rejections();
      test_short_ihl();
      test_register_extremes();
      test_random_traffic();

      settle_block();
      repeat (10) @(posedge clock);
      if (pending_verdicts.size() != 0)
         $display("%0d expected results never arrived", pending_verdicts.size());
      if (fault_count == 0 && pending_verdicts.size() == 0) begin
         $display("tb_tcp_port_frame_filter_top: done, clean");
      end else begin
         $display("tb_tcp_port_frame_filter_top: done, errors");
      end
      $finish;
   end

endmodule
